/* hdl/itj_pkg.sv */
package itj_pkg;

    localparam int unsigned QuatW  = 32;
    localparam int unsigned AccW   = 32;
    localparam int unsigned DiffW  = 33;
    localparam int unsigned ProdW  = 64;
    localparam int unsigned RowW   = 48;
    localparam int unsigned ColW   = 4;
    localparam int unsigned CfgW   = 32;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned NumCols = 6;
    localparam int unsigned SlotW   = 3;
    localparam int unsigned SumW    = 104;

    localparam logic [CfgIdxW-1:0] RegTimeStep  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegGyroDecay = 2'd1;
    localparam logic [CfgIdxW-1:0] RegAccDecay  = 2'd2;

    localparam logic [CfgW-1:0] ResetTimeStep  = 32'd42949673;
    localparam logic [CfgW-1:0] ResetGyroDecay = 32'd2146624836;
    localparam logic [CfgW-1:0] ResetAccDecay  = 32'd2147412067;

    // pairwise quaternion products, index of q_i*q_j
    typedef enum logic [3:0] {
        P00, P01, P02, P03, P11, P12, P13, P22, P23, P33
    } t_pair;

    typedef logic signed [ProdW-1:0] t_prods [10];

    // column numbers by output slot
    function automatic logic [ColW-1:0] col_of_slot(input logic [SlotW-1:0] s);
        logic [ColW-1:0] c;
        case (s)
            3'd0: c = 4'd6;
            3'd1: c = 4'd7;
            3'd2: c = 4'd8;
            3'd3: c = 4'd12;
            3'd4: c = 4'd13;
            default: c = 4'd14;
        endcase
        return c;
    endfunction

endpackage

/* hdl/itj_scale.sv */
// Scale a Q.76 column sum by dt and by dt^2/2, saturating to 48 bits.
// Three register stages: truncate, split multiply, recombine and saturate.
module itj_scale
    import itj_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [SumW-1:0]      i_sum,
    input  logic        [CfgW-1:0]      i_dt,
    input  logic        [CfgW-1:0]      i_hdt2,
    output logic signed [RowW-1:0]      o_pos,
    output logic signed [RowW-1:0]      o_vel
);

    logic signed [59:0] r_s32;
    logic signed [63:0] r_pos_lo;
    logic signed [63:0] r_vel_lo;
    logic signed [62:0] r_pos_hi;
    logic signed [62:0] r_vel_hi;
    logic signed [92:0] w_pos_p;
    logic signed [92:0] w_vel_p;
    logic signed [60:0] w_pos_sh;
    logic signed [60:0] w_vel_sh;

    function automatic logic signed [RowW-1:0] sat48(input logic signed [60:0] v);
        logic signed [RowW-1:0] r;
        if (v > 61'sh7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -61'sh8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = v[RowW-1:0];
        return r;
    endfunction

    // recombine the two partial products: high half sits 30 bits up
    assign w_pos_p  = (93'(r_pos_hi) <<< 30) + 93'(r_pos_lo);
    assign w_vel_p  = (93'(r_vel_hi) <<< 30) + 93'(r_vel_lo);
    assign w_pos_sh = w_pos_p[92:32];
    assign w_vel_sh = w_vel_p[92:32];

    // stage pipeline, all advance together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s32    <= i_sum[SumW-1:44];
            r_pos_lo <= $signed({1'b0, r_s32[29:0]}) * $signed({1'b0, i_hdt2});
            r_pos_hi <= $signed(r_s32[59:30]) * $signed({1'b0, i_hdt2});
            r_vel_lo <= $signed({1'b0, r_s32[29:0]}) * $signed({1'b0, i_dt});
            r_vel_hi <= $signed(r_s32[59:30]) * $signed({1'b0, i_dt});
            o_pos    <= sat48(w_pos_sh);
            o_vel    <= sat48(w_vel_sh);
        end
    end

endmodule

/* hdl/ins_transition_jacobian.sv */
// Columns follow the first one at one column per cycle, unless m_tready stalls the pipe.
// A new sample waits on the single output column lane;
//   the column sequencer holds s_tready low while emitting columns 1 to 5.
// Pipeline stalls only on m_tready; a stall freezes every stage.
// Reset (synchronous, active low) clears valid bits and restores register defaults.
module ins_transition_jacobian
    import itj_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgW-1:0]      i_cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // quat_w, quat_x, quat_y, quat_z, accel_x/y/z, bias_x/y/z (32b each, low first)
    input  logic [319:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // column_index(4), pos_row_x/y/z, vel_row_x/y/z (48b each), zero pad(4)
    output logic [295:0]         m_tdata,
    output logic                 m_tlast
);

    localparam int unsigned Depth = 8;

    logic [CfgW-1:0] r_dt, r_gdec, r_adec;
    logic [CfgW-1:0] r_hdt2;
    logic [63:0]     w_dt2;

    logic                       w_en;
    logic [Depth-1:0]           r_vld;
    logic [SlotW-1:0]           r_slot;
    logic                       r_busy;

    logic signed [QuatW-1:0]    r_q [4];
    logic signed [DiffW-1:0]    r_d [3];
    t_prods                     r_p;
    logic signed [DiffW-1:0]    r_d2 [3];
    logic [SlotW-1:0]           r_slot_p [Depth];
    logic signed [SumW-1:0]     r_sum [3];
    logic signed [SumW-1:0]     n_sum [3];
    logic signed [RowW-1:0]     w_pos [3];
    logic signed [RowW-1:0]     w_vel [3];
    logic signed [ProdW+3:0]    n_w [3][4];

    // configuration registers; decay values are only stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= ResetTimeStep;
            r_gdec <= ResetGyroDecay;
            r_adec <= ResetAccDecay;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegTimeStep:  r_dt   <= i_cfg_data;
                RegGyroDecay: r_gdec <= i_cfg_data;
                RegAccDecay:  r_adec <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_dt2 = r_dt * r_dt;
    always_ff @(posedge i_clk) r_hdt2 <= {1'b0, w_dt2[63:33]};

    // whole pipe advances unless the output register is full and stalled
    assign w_en     = !(m_tvalid && !m_tready);
    assign s_tready = w_en && !r_busy;

    // column sequencer: replays the accepted sample for slots 1..5
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (w_en) begin
            if (s_tvalid && s_tready) begin
                r_busy <= 1'b1;
                r_slot <= 3'd1;
            end else if (r_busy) begin
                r_slot <= r_slot + 3'd1;
                if (r_slot == 3'(NumCols - 1)) r_busy <= 1'b0;
            end
        end
    end

    // stage 0: capture sample, form d = accel - bias
    always_ff @(posedge i_clk) begin
        if (w_en && s_tvalid && s_tready) begin
            for (int k = 0; k < 4; k++) r_q[k] <= s_tdata[32*k +: 32];
            for (int k = 0; k < 3; k++)
                r_d[k] <= DiffW'($signed(s_tdata[128+32*k +: 32]))
                        - DiffW'($signed(s_tdata[224+32*k +: 32]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[Depth-2:0], (s_tvalid && s_tready) || r_busy};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_slot_p[0] <= (s_tvalid && s_tready) ? 3'd0 : r_slot;
            for (int k = 1; k < Depth; k++) r_slot_p[k] <= r_slot_p[k-1];
        end
    end

    // stage 1: quaternion pair products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[P00] <= r_q[0] * r_q[0];
            r_p[P01] <= r_q[0] * r_q[1];
            r_p[P02] <= r_q[0] * r_q[2];
            r_p[P03] <= r_q[0] * r_q[3];
            r_p[P11] <= r_q[1] * r_q[1];
            r_p[P12] <= r_q[1] * r_q[2];
            r_p[P13] <= r_q[1] * r_q[3];
            r_p[P22] <= r_q[2] * r_q[2];
            r_p[P23] <= r_q[2] * r_q[3];
            r_p[P33] <= r_q[3] * r_q[3];
            for (int k = 0; k < 3; k++) r_d2[k] <= r_d[k];
        end
    end

    // weighted pair sums per row and d selector (3 = constant one), by slot
    always_comb begin
        for (int r = 0; r < 3; r++)
            for (int s = 0; s < 4; s++) n_w[r][s] = '0;
        case (r_slot_p[1])
            3'd0: begin
                n_w[0][1] = 4*r_p[P02] + 4*r_p[P13];
                n_w[0][2] = 4*r_p[P03] - 4*r_p[P12];
                n_w[1][1] = -4*r_p[P01] + 4*r_p[P23];
                n_w[1][2] = 2*r_p[P33] - 2*r_p[P22] + 2*r_p[P11] - 2*r_p[P00];
                n_w[2][1] = 2*r_p[P33] - 2*r_p[P22] - 2*r_p[P11] + 2*r_p[P00];
                n_w[2][2] = -4*r_p[P01] - 4*r_p[P23];
            end
            3'd1: begin
                n_w[0][0] = -4*r_p[P02] - 4*r_p[P13];
                n_w[0][2] = 2*r_p[P00] + 2*r_p[P11] - 2*r_p[P22] - 2*r_p[P33];
                n_w[1][0] = 4*r_p[P01] - 4*r_p[P23];
                n_w[1][2] = 4*r_p[P03] + 4*r_p[P12];
                n_w[2][0] = -2*r_p[P33] + 2*r_p[P11] + 2*r_p[P22] - 2*r_p[P00];
                n_w[2][2] = -4*r_p[P02] + 4*r_p[P13];
            end
            3'd2: begin
                n_w[0][0] = -4*r_p[P03] + 4*r_p[P12];
                n_w[0][1] = 2*r_p[P22] - 2*r_p[P11] + 2*r_p[P33] - 2*r_p[P00];
                n_w[1][0] = 2*r_p[P00] - 2*r_p[P11] + 2*r_p[P22] - 2*r_p[P33];
                n_w[1][1] = -4*r_p[P03] - 4*r_p[P12];
                n_w[2][0] = 4*r_p[P23] + 4*r_p[P01];
                n_w[2][1] = 4*r_p[P02] - 4*r_p[P13];
            end
            3'd3: begin
                n_w[0][3] = -r_p[P00] - r_p[P11] + r_p[P22] + r_p[P33];
                n_w[1][3] = -2*r_p[P12] - 2*r_p[P03];
                n_w[2][3] = -2*r_p[P13] + 2*r_p[P02];
            end
            3'd4: begin
                n_w[0][3] = -2*r_p[P12] + 2*r_p[P03];
                n_w[1][3] = -r_p[P00] + r_p[P11] - r_p[P22] + r_p[P33];
                n_w[2][3] = -2*r_p[P23] - 2*r_p[P01];
            end
            default: begin
                n_w[0][3] = -2*r_p[P13] - 2*r_p[P02];
                n_w[1][3] = -2*r_p[P23] + 2*r_p[P01];
                n_w[2][3] = -r_p[P00] + r_p[P11] + r_p[P22] - r_p[P33];
            end
        endcase
    end

    // stage 2: register weighted sums (fit 68 bits, stored as 64+4 via n_w)
    logic signed [ProdW+3:0] r_wx [3][4];
    logic signed [DiffW-1:0] r_d3 [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++)
                for (int s = 0; s < 4; s++) r_wx[r][s] <= n_w[r][s];
            for (int k = 0; k < 3; k++) r_d3[k] <= r_d2[k];
        end
    end

    // stage 3: multiply by d, each 68-bit weight split at bit 34 into low/high products
    logic signed [67:0]     r_tl [3][3];
    logic signed [66:0]     r_th [3][3];
    logic signed [SumW-1:0] r_tc [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int s = 0; s < 3; s++) begin
                    r_tl[r][s] <= $signed({1'b0, r_wx[r][s][33:0]}) * r_d3[s];
                    r_th[r][s] <= $signed(r_wx[r][s][ProdW+3:34]) * r_d3[s];
                end
                r_tc[r] <= SumW'(r_wx[r][3]) <<< 16;
            end
        end
    end

    // stage 4: recombine the partial products and sum the terms of each row
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = r_tc[r];
            for (int s = 0; s < 3; s++)
                n_sum[r] = n_sum[r] + (SumW'(r_th[r][s]) <<< 34) + SumW'(r_tl[r][s]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) for (int r = 0; r < 3; r++) r_sum[r] <= n_sum[r];
    end

    // stages 5..7: scale and saturate
    for (genvar g = 0; g < 3; g++) begin : g_row
        itj_scale u_scale (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sum  (r_sum[g]),
            .i_dt   (r_dt),
            .i_hdt2 (r_hdt2),
            .o_pos  (w_pos[g]),
            .o_vel  (w_vel[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_tvalid <= 1'b0;
        else if (w_en) m_tvalid <= r_vld[Depth-1];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_tdata <= {4'd0, w_vel[2], w_vel[1], w_vel[0], w_pos[2], w_pos[1], w_pos[0],
                        col_of_slot(r_slot_p[Depth-1])};
            m_tlast <= (r_slot_p[Depth-1] == 3'(NumCols - 1));
        end
    end

    // decay registers are held for the register map only
    logic unused_w;
    assign unused_w = ^{r_gdec, r_adec};

endmodule

/* test/tb_ins_transition_jacobian.sv */
`timescale 1ns / 1ps

module tb_ins_transition_jacobian;
    import itj_pkg::*;

    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
    localparam int IdleLimit = 20000;
    localparam int DrainCycles = 16;

    // coefficient list: slot, row, accel select (3 = unity), q_i, q_j, weight
    localparam int CoefTab [72][6] = '{
        '{0,0,1,0,2,4},'{0,0,1,1,3,4},'{0,0,2,0,3,4},'{0,0,2,1,2,-4},
        '{0,1,1,0,1,-4},'{0,1,1,2,3,4},'{0,1,2,3,3,2},'{0,1,2,2,2,-2},'{0,1,2,1,1,2},
        '{0,1,2,0,0,-2},
        '{0,2,1,3,3,2},'{0,2,1,2,2,-2},'{0,2,1,1,1,-2},'{0,2,1,0,0,2},'{0,2,2,0,1,-4},
        '{0,2,2,2,3,-4},
        '{1,0,0,0,2,-4},'{1,0,0,1,3,-4},'{1,0,2,0,0,2},'{1,0,2,1,1,2},'{1,0,2,2,2,-2},
        '{1,0,2,3,3,-2},
        '{1,1,0,0,1,4},'{1,1,0,2,3,-4},'{1,1,2,0,3,4},'{1,1,2,1,2,4},
        '{1,2,0,3,3,-2},'{1,2,0,1,1,2},'{1,2,0,2,2,2},'{1,2,0,0,0,-2},'{1,2,2,0,2,-4},
        '{1,2,2,1,3,4},
        '{2,0,0,0,3,-4},'{2,0,0,1,2,4},'{2,0,1,2,2,2},'{2,0,1,1,1,-2},'{2,0,1,3,3,2},
        '{2,0,1,0,0,-2},
        '{2,1,0,0,0,2},'{2,1,0,1,1,-2},'{2,1,0,2,2,2},'{2,1,0,3,3,-2},'{2,1,1,0,3,-4},
        '{2,1,1,1,2,-4},
        '{2,2,0,2,3,4},'{2,2,0,0,1,4},'{2,2,1,0,2,4},'{2,2,1,1,3,-4},
        '{3,0,3,0,0,-1},'{3,0,3,1,1,-1},'{3,0,3,2,2,1},'{3,0,3,3,3,1},
        '{3,1,3,1,2,-2},'{3,1,3,0,3,-2},'{3,2,3,1,3,-2},'{3,2,3,0,2,2},
        '{4,0,3,1,2,-2},'{4,0,3,0,3,2},
        '{4,1,3,0,0,-1},'{4,1,3,1,1,1},'{4,1,3,2,2,-1},'{4,1,3,3,3,1},
        '{4,2,3,2,3,-2},'{4,2,3,0,1,-2},
        '{5,0,3,1,3,-2},'{5,0,3,0,2,-2},'{5,1,3,2,3,-2},'{5,1,3,0,1,2},
        '{5,2,3,0,0,-1},'{5,2,3,1,1,1},'{5,2,3,2,2,1},'{5,2,3,3,3,-1}
    };

    typedef struct {
        logic [ColW-1:0] col;
        logic [RowW-1:0] row [6];
        logic            last;
    } t_column;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgW-1:0] i_cfg_data = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [319:0]   s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [295:0]   m_tdata;
    logic           m_tlast;

    logic [CfgW-1:0] dt_reg;
    t_column        column_q [$];
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_off_cycles = 0;
    int             mismatches = 0;
    int             idle_count = 0;

    ins_transition_jacobian uut (.*);

    always #1 i_clk = ~i_clk;

    // scale Q.32 sum by an unsigned factor, drop 32 bits, clamp to 48 bits
    function automatic logic [RowW-1:0] scale_sat(input logic [31:0] factor,
                                                  input longint s32);
        logic signed [127:0] f;
        logic signed [127:0] s;
        logic signed [127:0] m;
        longint r;
        f = {96'd0, factor};
        s = s32;
        m = f * s;
        r = m[95:32];
        if (r > 64'sd140737488355327) r = 64'sd140737488355327;
        if (r < -64'sd140737488355328) r = -64'sd140737488355328;
        return r[RowW-1:0];
    endfunction

    // work out the six Jacobian columns for one sample
    function automatic void predict_columns(input logic [319:0] data);
        longint q [4];
        longint d [4];
        logic signed [127:0] acc;
        logic signed [127:0] dd;
        logic signed [127:0] pp;
        logic [31:0] half_dt2;
        logic [63:0] dt_sq;
        longint s32;
        t_column c;
        for (int k = 0; k < 4; k++) q[k] = longint'($signed(data[32*k +: 32]));
        for (int k = 0; k < 3; k++)
            d[k] = longint'($signed(data[128 + 32*k +: 32]))
                 - longint'($signed(data[224 + 32*k +: 32]));
        d[3] = 65536;
        dt_sq = {32'd0, dt_reg} * {32'd0, dt_reg};
        half_dt2 = {1'b0, dt_sq[63:33]};
        for (int k = 0; k < NumCols; k++) begin
            c.col = col_of_slot(k[SlotW-1:0]);
            for (int r = 0; r < 3; r++) begin
                acc = '0;
                for (int t = 0; t < 72; t++) begin
                    if (CoefTab[t][0] == k && CoefTab[t][1] == r) begin
                        dd = d[CoefTab[t][2]];
                        pp = q[CoefTab[t][3]] * q[CoefTab[t][4]];
                        acc = acc + dd * pp * CoefTab[t][5];
                    end
                end
                s32 = acc[107:44];
                c.row[r] = scale_sat(half_dt2, s32);
                c.row[r+3] = scale_sat(dt_reg, s32);
            end
            c.last = (k == NumCols - 1);
            column_q.push_back(c);
        end
    endfunction

    // offer one sample, hold it until the block takes it
    task automatic send_sample(input logic [319:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_columns(data);
    endtask

    task automatic send_fields(input logic [31:0] qw, qx, qy, qz,
                               input logic [31:0] ax, ay, az, bx, by, bz);
        send_sample({bz, by, bx, az, ay, ax, qz, qy, qx, qw});
    endtask

    function automatic logic [31:0] rand_word(input int mode);
        logic [31:0] v;
        v = $urandom;
        case (mode)
            0: v = $signed(v) >>> 20;
            1: v = $signed(v) >>> 1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_random();
        logic [31:0] f [10];
        int qm;
        int am;
        qm = $urandom_range(2);
        am = $urandom_range(2);
        for (int i = 0; i < 4; i++) f[i] = rand_word(qm);
        for (int i = 4; i < 10; i++) f[i] = rand_word(am);
        send_fields(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]);
    endtask

    // wait for every column to leave, then let the pipeline empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (column_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegTimeStep) dt_reg = val;
    endtask

    task automatic test_extremes();
        send_fields(32'h4000_0000, 0, 0, 0, 32'h0001_0000, 0, 32'h0009_CE00, 0, 0, 0);
        send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0);
        // unnormalised quaternion
        send_fields(32'h2000_0000, 32'h1000_0000, 32'hF000_0000, 32'h3000_0000,
                    32'h0003_0000, 32'hFFFD_0000, 32'h0010_0000, 32'h0000_8000, 0, 0);
        send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_config_sweep();
        // largest step saturates rows, zero step clears them
        write_reg(RegTimeStep, 32'hFFFF_FFFF);
        write_reg(RegGyroDecay, 32'h8000_0000);
        write_reg(RegAccDecay, 32'h0000_0000);
        test_extremes();
        write_reg(RegTimeStep, 32'h0000_0000);
        write_reg(RegGyroDecay, 32'h0000_0000);
        write_reg(RegAccDecay, 32'h8000_0000);
        test_extremes();
        write_reg(RegTimeStep, 32'h8000_0001);
        // out-of-range index must be ignored
        write_reg(RegUnused, 32'h1234_5678);
        repeat (4) send_random();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 300;
        repeat (12) send_random();
    endtask

    // take columns, compare with the oldest expectation, drive ready
    always @(posedge i_clk) begin
        t_column e;
        logic [RowW-1:0] got [6];
        logic bad;
        if (i_rst_n && m_tvalid && m_tready) begin
            for (int r = 0; r < 6; r++) got[r] = m_tdata[4 + RowW*r +: RowW];
            if (column_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected column %0d", m_tdata[3:0]);
            end else begin
                e = column_q.pop_front();
                bad = (e.col != m_tdata[3:0]) || (e.last != m_tlast);
                for (int r = 0; r < 6; r++) bad |= (e.row[r] != got[r]);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: col exp %0d got %0d last exp %0d got %0d rows exp %h %h %h %h %h %h got %h %h %h %h %h %h",
                                 e.col, m_tdata[3:0], e.last, m_tlast,
                                 e.row[0], e.row[1], e.row[2], e.row[3], e.row[4], e.row[5],
                                 got[0], got[1], got[2], got[3], got[4], got[5]);
                end
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        dt_reg = ResetTimeStep;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_config_sweep();
        write_reg(RegTimeStep, ResetTimeStep);
        test_random(40, 24, 71);
        test_random(40, 71, 24);
        test_random(40, 0, 0);
        test_backpressure();
        wait_drained();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/itj_pkg.sv
hdl/itj_scale.sv
hdl/ins_transition_jacobian.sv
test/tb_ins_transition_jacobian.sv
